// File: hw/rtl/form_field_extract_url_decode_defines.svh
// Assertion macros shared by the form field extractor RTL.
`ifndef FORM_FIELD_EXTRACT_URL_DECODE_DEFINES_SVH
`define FORM_FIELD_EXTRACT_URL_DECODE_DEFINES_SVH

// Same-cycle implication, checked on clk with reset masked
`define FFUD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk with reset masked
`define FFUD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ffud_pkg.sv
// Types, character codes and helpers for the form field extractor.
`default_nettype none

package ffud_pkg;

    // Characters of the form encoding
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;

    // Register indexes (byte address bits [4:3])
    localparam logic [1:0] REG_KEY_BYTES = 2'd0;
    localparam logic [1:0] REG_KEY_LEN   = 2'd1;
    localparam logic [1:0] REG_MAX_LEN   = 2'd2;

    // Result queue
    localparam int QDEPTH  = 8;
    localparam int QCNT_W  = 4;
    localparam int QIDX_W  = 3;
    localparam int LEN_W   = 11;

    typedef struct packed {
        logic             kind;
        logic [7:0]       value_byte;
        logic             found;
        logic [LEN_W-1:0] value_length;
        logic             final_res;
    } res_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h61) && (c <= 8'h66)) ||
            ((c >= 8'h41) && (c <= 8'h46));
        return r;
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] t;
        if (c <= 8'h39)
        begin
            t = c - 8'h30;
        end
        else
        begin
            t = (c | 8'h20) - 8'h61 + 8'd10;
        end
        return t[3:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/form_field_extract_url_decode.sv
// Form field extractor: finds one named field in a form body and percent-decodes its value.
`default_nettype none

// Takes one body byte per cycle when not stalled and scans key=value pairs separated by '&'.
// The first pair whose key matches key_bytes/key_length has its value decoded
// ('+' to space, '%HH' to one byte, a broken escape copied verbatim) and sent
// out byte by byte up to max_value_length, followed by one completion item
// carrying found and the delivered length; the rest of that body is dropped.
// Each input item is handled in its cycle of acceptance and gives zero to four
// result items, which go into an eight-entry result queue drained at one item
// per cycle while out_stall is low. An input item is taken in every cycle while
// the queue holds four or fewer results, so the input runs at one item per cycle
// whenever the output keeps up, and the output port sets the rate when an item
// expands to several results (an escape flushed at the value end gives up to four).
// With the output never stalled and the queue empty, the first result of an item
// is offered and leaves in the cycle after its acceptance; further results follow
// at one per cycle, behind any earlier results still waiting in the queue.

`include "form_field_extract_url_decode_defines.svh"

module form_field_extract_url_decode
    import ffud_pkg::*;
#(
    parameter int MAX_KEY_BYTES   = 8,
    parameter int MAX_VALUE_BYTES = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    // input items
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        body_byte,
    input  wire logic              body_end,
    // result items
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   kind,
    output logic      [7:0]        value_byte,
    output logic                   found,
    output logic      [LEN_W-1:0]  value_length,
    output logic                   final_res
);

    typedef enum logic [1:0] {
        PH_KEY,
        PH_MATCH,
        PH_SKIP,
        PH_DONE
    } phase_t;

    localparam logic [3:0]  MAXK = 4'(MAX_KEY_BYTES);
    localparam logic [16:0] MAXV = 17'(MAX_VALUE_BYTES);

    // configuration registers
    logic [63:0]      key_bytes_reg;
    logic [3:0]       key_len_reg;
    logic [LEN_W-1:0] max_len_reg;

    // scan state
    phase_t           ph_reg, ph_next;
    logic             ksm_reg, ksm_next;
    logic [3:0]       kp_reg, kp_next;
    logic [1:0]       pc_reg, pc_next;
    logic [7:0]       phc_reg, phc_next;
    logic [LEN_W-1:0] dc_reg, dc_next;

    // result queue
    res_t             q_reg [QDEPTH];
    res_t             q_next [QDEPTH];
    res_t             q_shift [QDEPTH];
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    logic             acc;
    logic             pop;
    logic             cfg_wr;
    logic [1:0]       cfg_idx;

    // per-item decode
    logic [7:0]       em [3];
    logic [1:0]       ne;
    logic             rep;
    logic             rep_hit;
    logic             do_plain;
    logic             hit;
    logic [16:0]      cap;
    logic [2:0]       ok;
    logic [2:0]       n_out;
    logic [2:0]       nres;
    res_t             res [4];
    logic [QCNT_W-1:0] base;
    logic [QCNT_W-1:0] off;

    assign acc    = in_valid && !in_stall;
    assign pop    = out_valid && !out_stall;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];

    // handshake and read-back
    assign pready    = 1'b1;
    assign in_stall  = cnt_reg > QCNT_W'(QDEPTH - 4);
    assign out_valid = cnt_reg != '0;

    always_comb
    begin
        case (cfg_idx)
            REG_KEY_BYTES: prdata = key_bytes_reg;
            REG_KEY_LEN:   prdata = {60'd0, key_len_reg};
            REG_MAX_LEN:   prdata = {53'd0, max_len_reg};
            default:       prdata = '0;
        endcase
    end

    assign kind         = q_reg[0].kind;
    assign value_byte   = q_reg[0].value_byte;
    assign found        = q_reg[0].found;
    assign value_length = q_reg[0].value_length;
    assign final_res    = q_reg[0].final_res;

    // effective output cap
    assign cap = ({6'd0, max_len_reg} > MAXV) ? MAXV : {6'd0, max_len_reg};

    // scan and decode of one body byte
    always_comb
    begin
        ph_next  = ph_reg;
        ksm_next = ksm_reg;
        kp_next  = kp_reg;
        pc_next  = pc_reg;
        phc_next = phc_reg;
        em       = '{default: '0};
        ne       = '0;
        rep      = 1'b0;
        rep_hit  = 1'b0;
        do_plain = 1'b0;
        hit      = ksm_reg && (key_len_reg <= MAXK) && (kp_reg == key_len_reg);

        case (ph_reg)
            PH_KEY:
            begin
                rep = body_end;
                if (body_byte == CH_EQ)
                begin
                    ph_next = hit ? PH_MATCH : PH_SKIP;
                    rep_hit = hit;
                end
                else if (body_byte == CH_AMP)
                begin
                    ksm_next = 1'b1;
                    kp_next  = '0;
                end
                else
                begin
                    if ((kp_reg >= key_len_reg) || (kp_reg >= MAXK) ||
                        (key_bytes_reg[{kp_reg[2:0], 3'b000} +: 8] != body_byte))
                    begin
                        ksm_next = 1'b0;
                    end
                    if (kp_reg <= MAXK)
                    begin
                        kp_next = kp_reg + 4'd1;
                    end
                end
            end
            PH_SKIP:
            begin
                rep = body_end;
                if (body_byte == CH_AMP)
                begin
                    ph_next  = PH_KEY;
                    ksm_next = 1'b1;
                    kp_next  = '0;
                end
            end
            PH_MATCH:
            begin
                if (body_byte != CH_AMP)
                begin
                    // escape state in front of this byte
                    case (pc_reg)
                        2'd0:
                        begin
                            do_plain = 1'b1;
                        end
                        2'd1:
                        begin
                            if (is_hex(body_byte))
                            begin
                                pc_next  = 2'd2;
                                phc_next = body_byte;
                            end
                            else
                            begin
                                pc_next  = 2'd0;
                                em[ne]   = CH_PCT;
                                ne       = ne + 2'd1;
                                do_plain = 1'b1;
                            end
                        end
                        2'd2:
                        begin
                            pc_next = 2'd0;
                            if (is_hex(body_byte))
                            begin
                                em[ne] = {nibble(phc_reg), nibble(body_byte)};
                                ne     = ne + 2'd1;
                            end
                            else
                            begin
                                em[ne]   = CH_PCT;
                                ne       = ne + 2'd1;
                                em[ne]   = phc_reg;
                                ne       = ne + 2'd1;
                                do_plain = 1'b1;
                            end
                            phc_next = '0;
                        end
                        default:
                        begin
                            pc_next = 2'd0;
                        end
                    endcase
                    if (do_plain)
                    begin
                        if (body_byte == CH_PLUS)
                        begin
                            em[ne] = CH_SPACE;
                            ne     = ne + 2'd1;
                        end
                        else if (body_byte == CH_PCT)
                        begin
                            pc_next = 2'd1;
                        end
                        else
                        begin
                            em[ne] = body_byte;
                            ne     = ne + 2'd1;
                        end
                    end
                end
                // value end: flush a broken escape and report
                if ((body_byte == CH_AMP) || body_end)
                begin
                    if (pc_next != 2'd0)
                    begin
                        em[ne] = CH_PCT;
                        ne     = ne + 2'd1;
                    end
                    if (pc_next == 2'd2)
                    begin
                        em[ne] = phc_next;
                        ne     = ne + 2'd1;
                    end
                    pc_next  = 2'd0;
                    phc_next = '0;
                    rep      = 1'b1;
                    rep_hit  = 1'b1;
                    ph_next  = PH_DONE;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // start of the next body
        if (body_end)
        begin
            ph_next  = PH_KEY;
            ksm_next = 1'b1;
            kp_next  = '0;
            pc_next  = 2'd0;
            phc_next = '0;
        end
    end

    // bytes that fit under the cap
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ok[k] = (({6'd0, dc_reg} + 17'(k)) < cap) && (ne > 2'(k));
        end
        n_out = 3'(ok[0]) + 3'(ok[1]) + 3'(ok[2]);
        nres  = n_out + 3'(rep);
        dc_next = body_end ? '0 : (dc_reg + LEN_W'(n_out));
    end

    // result list of this item: decoded bytes, then the report
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (3'(k) < n_out)
            begin
                res[k].kind         = 1'b0;
                res[k].value_byte   = em[k[1:0] == 2'd3 ? 2'd0 : k[1:0]];
                res[k].found        = 1'b0;
                res[k].value_length = '0;
                res[k].final_res    = 1'b0;
            end
            else
            begin
                res[k].kind         = 1'b1;
                res[k].value_byte   = '0;
                res[k].found        = rep_hit;
                res[k].value_length = rep_hit ? (dc_reg + LEN_W'(n_out)) : '0;
                res[k].final_res    = 1'b1;
            end
        end
    end

    // result queue: shift out at the head, append behind the survivors
    always_comb
    begin
        for (int i = 0; i < QDEPTH - 1; i++)
        begin
            q_shift[i] = q_reg[i + 1];
        end
        q_shift[QDEPTH-1] = q_reg[QDEPTH-1];

        base = cnt_reg - QCNT_W'(pop);
        for (int i = 0; i < QDEPTH; i++)
        begin
            off = QCNT_W'(i) - base;
            if (QCNT_W'(i) < base)
            begin
                q_next[i] = pop ? q_shift[i] : q_reg[i];
            end
            else if (acc && (off < QCNT_W'(nres)))
            begin
                q_next[i] = res[off[1:0]];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
        end
        cnt_next = base + (acc ? QCNT_W'(nres) : '0);
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg <= '0;
            key_len_reg   <= 4'd8;
            max_len_reg   <= LEN_W'(1024);
            ph_reg        <= PH_KEY;
            ksm_reg       <= 1'b1;
            kp_reg        <= '0;
            pc_reg        <= 2'd0;
            phc_reg       <= '0;
            dc_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_KEY_BYTES: key_bytes_reg <= pwdata;
                    REG_KEY_LEN:   key_len_reg   <= pwdata[3:0];
                    REG_MAX_LEN:   max_len_reg   <= pwdata[LEN_W-1:0];
                    default:       ;
                endcase
            end
            if (acc)
            begin
                ph_reg  <= ph_next;
                ksm_reg <= ksm_next;
                kp_reg  <= kp_next;
                pc_reg  <= pc_next;
                phc_reg <= phc_next;
                dc_reg  <= dc_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // checks
    `FFUD_ASSERT_IMPL(a_queue_bound, 1'b1, cnt_reg <= QCNT_W'(QDEPTH), "result queue overrun")
    `FFUD_ASSERT_IMPL(a_report, out_valid && kind, final_res && value_byte == '0, "bad report")
    `FFUD_ASSERT_IMPL(a_notfound_len, out_valid && kind && !found, value_length == '0, "bad miss")
    `FFUD_ASSERT_IMPL(a_escape_phase, pc_reg != 2'd0, ph_reg == PH_MATCH, "stray escape")
    `FFUD_ASSERT_NEXT(a_stall_full, in_stall, cnt_reg <= QCNT_W'(QDEPTH), "queue overfilled")

endmodule

`default_nettype wire

// File: verif/url_field_checker.sv
// Checker for the form field extractor: tracks register writes, predicts and compares result items.
module url_field_checker
    import ffud_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic             pready,
    input  wire logic [4:0]       paddr,
    input  wire logic [63:0]      pwdata,
    input  wire logic             in_valid,
    input  wire logic             in_stall,
    input  wire logic [7:0]       body_byte,
    input  wire logic             body_end,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire logic             kind,
    input  wire logic [7:0]       value_byte,
    input  wire logic             found,
    input  wire logic [LEN_W-1:0] value_length,
    input  wire logic             final_res,
    output int                    fail_count,
    output int                    outstanding,
    output int                    bytes_seen,
    output int                    reports_seen,
    output int                    hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_LIMIT   = 8;
    localparam int VALUE_LIMIT = 1024;

    typedef enum logic [1:0] {SCAN_KEY, COPY_VALUE, SKIP_PAIR, BODY_DONE} scan_phase_t;

    // register copies
    logic [63:0]      name_word;
    logic [3:0]       match_len;
    logic [10:0]      value_cap;

    // body scan state
    scan_phase_t      scan_phase;
    bit               name_ok;
    int               name_pos;
    int               esc_count;
    logic [7:0]       esc_digit;
    int               delivered;

    res_t             decoded_q[$];

    function automatic void start_body();
        scan_phase = SCAN_KEY;
        name_ok    = 1'b1;
        name_pos   = 0;
        esc_count  = 0;
        esc_digit  = 8'h00;
        delivered  = 0;
    endfunction

    // hex digit test: bit 4 marks a digit, bits 3..0 give its value
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] v;
        v = 5'd0;
        if (c >= "0" && c <= "9")
        begin
            d = c - "0";
            v = {1'b1, d[3:0]};
        end
        else if (c >= "a" && c <= "f")
        begin
            d = c - "a" + 8'd10;
            v = {1'b1, d[3:0]};
        end
        else if (c >= "A" && c <= "F")
        begin
            d = c - "A" + 8'd10;
            v = {1'b1, d[3:0]};
        end
        return v;
    endfunction

    // one decoded byte, dropped once the cap is reached
    function automatic void deliver(input logic [7:0] b);
        int   limit;
        res_t r;
        limit = (value_cap > VALUE_LIMIT) ? VALUE_LIMIT : int'(value_cap);
        if (delivered < limit)
        begin
            r            = '0;
            r.value_byte = b;
            decoded_q.push_back(r);
            delivered++;
        end
    endfunction

    function automatic void report(input bit hit);
        res_t r;
        r              = '0;
        r.kind         = 1'b1;
        r.found        = hit;
        r.value_length = hit ? delivered[LEN_W-1:0] : '0;
        r.final_res    = 1'b1;
        decoded_q.push_back(r);
    endfunction

    function automatic void plain_char(input logic [7:0] b);
        if (b == CH_PLUS)
            deliver(CH_SPACE);
        else if (b == CH_PCT)
            esc_count = 1;
        else
            deliver(b);
    endfunction

    // percent decoding with up to two held characters
    function automatic void decode_char(input logic [7:0] b);
        logic [4:0] h;
        logic [4:0] hi;
        h = hex_value(b);
        if (esc_count == 0)
        begin
            plain_char(b);
        end
        else if (esc_count == 1)
        begin
            if (h[4])
            begin
                esc_count = 2;
                esc_digit = b;
            end
            else
            begin
                esc_count = 0;
                deliver(CH_PCT);
                plain_char(b);
            end
        end
        else
        begin
            esc_count = 0;
            if (h[4])
            begin
                hi = hex_value(esc_digit);
                deliver({hi[3:0], h[3:0]});
            end
            else
            begin
                deliver(CH_PCT);
                deliver(esc_digit);
                plain_char(b);
            end
            esc_digit = 8'h00;
        end
    endfunction

    function automatic void flush_escape();
        if (esc_count >= 1)
            deliver(CH_PCT);
        if (esc_count == 2)
            deliver(esc_digit);
        esc_count = 0;
        esc_digit = 8'h00;
    endfunction

    function automatic void predict_item(input logic [7:0] b, input logic last);
        bit         hit;
        logic [7:0] want;
        case (scan_phase)
            SCAN_KEY:
            begin
                if (b == CH_EQ)
                begin
                    hit = name_ok && match_len <= KEY_LIMIT && name_pos == int'(match_len);
                    scan_phase = hit ? COPY_VALUE : SKIP_PAIR;
                    if (last)
                        report(hit);
                end
                else if (b == CH_AMP)
                begin
                    name_ok  = 1'b1;
                    name_pos = 0;
                    if (last)
                        report(1'b0);
                end
                else
                begin
                    want = 8'((name_word >> (8 * name_pos)) & 64'hFF);
                    if (name_pos >= int'(match_len) || name_pos >= KEY_LIMIT || want != b)
                        name_ok = 1'b0;
                    if (name_pos <= KEY_LIMIT)
                        name_pos++;
                    if (last)
                        report(1'b0);
                end
            end
            SKIP_PAIR:
            begin
                if (b == CH_AMP)
                begin
                    scan_phase = SCAN_KEY;
                    name_ok    = 1'b1;
                    name_pos   = 0;
                end
                if (last)
                    report(1'b0);
            end
            COPY_VALUE:
            begin
                if (b == CH_AMP || last)
                begin
                    if (b != CH_AMP)
                        decode_char(b);
                    flush_escape();
                    report(1'b1);
                    scan_phase = BODY_DONE;
                end
                else
                begin
                    decode_char(b);
                end
            end
            default:
            begin
            end
        endcase
        if (last)
            start_body();
    endfunction

    function automatic void compare_result(input res_t got);
        res_t want;
        bit   bad;
        bad = 1'b0;
        if (got.kind)
        begin
            reports_seen++;
            if (got.found)
                hits_seen++;
        end
        else
        begin
            bytes_seen++;
        end
        if (decoded_q.size() == 0)
        begin
            $error("unexpected result item: kind %0d value_byte %02h", got.kind, got.value_byte);
            fail_count++;
        end
        else
        begin
            want = decoded_q.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                bad = 1'b1;
            end
            if (got.value_byte !== want.value_byte)
            begin
                $error("value_byte: expected %02h, got %02h", want.value_byte, got.value_byte);
                bad = 1'b1;
            end
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                bad = 1'b1;
            end
            if (got.value_length !== want.value_length)
            begin
                $error("value_length: expected %0d, got %0d", want.value_length,
                       got.value_length);
                bad = 1'b1;
            end
            if (got.final_res !== want.final_res)
            begin
                $error("final_res: expected %0d, got %0d", want.final_res, got.final_res);
                bad = 1'b1;
            end
            if (bad)
                fail_count++;
        end
    endfunction

    // sample all three ports at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_q.delete();
            name_word   = 64'd0;
            match_len   = 4'd8;
            value_cap   = 11'd1024;
            start_body();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[4:3] == REG_KEY_BYTES)
                    name_word = pwdata;
                else if (paddr[4:3] == REG_KEY_LEN)
                    match_len = pwdata[3:0];
                else if (paddr[4:3] == REG_MAX_LEN)
                    value_cap = pwdata[10:0];
            end
            if (in_valid && !in_stall)
                predict_item(body_byte, body_end);
            if (out_valid && !out_stall)
                compare_result({kind, value_byte, found, value_length, final_res});
            outstanding = decoded_q.size();
        end
    end

endmodule

// File: verif/tb_form_field_extract_url_decode.sv
// Testbench top for the form field extractor: clock, reset, register writes, body stimulus.
module tb_form_field_extract_url_decode;
    import ffud_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [4:0]        paddr     = '0;
    logic [63:0]       pwdata    = '0;
    logic [63:0]       prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [7:0]        body_byte = 8'h00;
    logic              body_end  = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              kind;
    logic [7:0]        value_byte;
    logic              found;
    logic [LEN_W-1:0]  value_length;
    logic              final_res;

    int                fail_count;
    int                outstanding;
    int                bytes_seen;
    int                reports_seen;
    int                hits_seen;

    // stimulus bookkeeping
    logic              calm      = 1'b0;
    logic [63:0]       key_word  = 64'd0;
    logic [3:0]        key_len   = 4'd8;
    logic [7:0]        body_q[$];
    int                items_sent;
    int                bodies_sent;
    int                settings_used;

    form_field_extract_url_decode dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .body_byte    (body_byte),
        .body_end     (body_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .value_byte   (value_byte),
        .found        (found),
        .value_length (value_length),
        .final_res    (final_res)
    );

    url_field_checker checker_i
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .body_byte    (body_byte),
        .body_end     (body_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .value_byte   (value_byte),
        .found        (found),
        .value_length (value_length),
        .final_res    (final_res),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .bytes_seen   (bytes_seen),
        .reports_seen (reports_seen),
        .hits_seen    (hits_seen)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // random output stall, switched off during the calm stretch
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    // run limit
    initial
    begin
        #(2_000_000);
        $display("tb_form_field_extract_url_decode NOT OK");
        $finish;
    end

    // two-phase register write; psel drops for a cycle before the next one
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // hold the input back until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_fields(input logic [63:0] key, input logic [3:0] len,
                              input logic [10:0] cap);
        drain();
        // a trailing body may still be in flight with nothing to show for it
        repeat (4) @(negedge clk);
        write_reg(REG_KEY_BYTES, key);
        write_reg(REG_KEY_LEN, {60'd0, len});
        write_reg(REG_MAX_LEN, {53'd0, cap});
        key_word = key;
        key_len  = len;
        settings_used++;
    endtask

    task automatic send_item(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        body_byte <= b;
        body_end  <= last;
        do @(posedge clk); while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_body();
        if (body_q.size() == 0)
            body_q.push_back(8'($urandom_range(97, 122)));
        foreach (body_q[i])
            send_item(body_q[i], i == body_q.size() - 1);
        body_q.delete();
        bodies_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            body_q.push_back(s[i]);
        send_body();
    endtask

    function automatic logic [7:0] hex_char();
        string digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // key of a pair: mostly the configured name, else a near miss or random letters
    function automatic void add_key();
        int         kl;
        int         sel;
        logic [7:0] b;
        kl  = (key_len > 8) ? 8 : int'(key_len);
        sel = $urandom_range(0, 9);
        if (sel < 8)
        begin
            for (int i = 0; i < kl; i++)
            begin
                b = key_word[8*i +: 8];
                if (sel == 6 && i == kl - 1)
                    b = b ^ (8'd1 << $urandom_range(0, 7));
                if (!(sel == 5 && i == kl - 1))
                    body_q.push_back(b);
            end
            if (sel == 7)
                body_q.push_back(8'($urandom_range(97, 122)));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                body_q.push_back(8'($urandom_range(97, 122)));
        end
    endfunction

    // value of a pair: plain text, '+', good and broken escapes, any byte
    function automatic void add_value();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: body_q.push_back(8'($urandom_range(33, 126)));
                3:       body_q.push_back(CH_PLUS);
                4:
                begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back(hex_char());
                    body_q.push_back(hex_char());
                end
                5:       body_q.push_back(CH_PCT);
                6:
                begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back(hex_char());
                end
                7:
                begin
                    body_q.push_back(CH_PCT);
                    body_q.push_back(hex_char());
                    body_q.push_back(8'($urandom_range(103, 122)));
                end
                default: body_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // a body of one to four pairs, some of them noise or missing '='
    function automatic void make_body();
        int pairs;
        pairs = $urandom_range(1, 4);
        for (int p = 0; p < pairs; p++)
        begin
            if (p > 0)
                body_q.push_back(CH_AMP);
            if ($urandom_range(0, 99) < 8)
            begin
                repeat ($urandom_range(1, 5))
                    body_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                add_key();
                if ($urandom_range(0, 9) != 0)
                begin
                    body_q.push_back(CH_EQ);
                    add_value();
                end
            end
        end
        if ($urandom_range(0, 9) == 0)
            body_q.push_back(CH_AMP);
    endfunction

    task automatic random_bodies(input int target);
        int first;
        first = items_sent;
        while (items_sent - first < target)
        begin
            make_body();
            send_body();
            if ($urandom_range(0, 15) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-letter name, full cap
        set_fields(64'h6B, 4'd1, 11'd1024);
        // skipped pair, '+', good escape, bad escapes, ignored tail after the report
        send_text("x&k=+%4a%zq%4g&j");
        // escape cut short by the body end, with and without its held digit
        send_text("k=%4");
        send_text("k=%");
        // body ends before any match
        send_text("q");
        // empty value at the body end
        send_text("k=");
        random_bodies(45);

        // name of all-ones bytes at full length, tight cap
        set_fields(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 11'd3);
        random_bodies(45);

        // name of two zero bytes, no idling on either side
        calm <= 1'b1;
        set_fields(64'h0, 4'd2, 11'd1024);
        random_bodies(45);
        calm <= 1'b0;

        // empty name, nothing delivered
        set_fields({$urandom, $urandom}, 4'd0, 11'd0);
        random_bodies(45);

        // name too long to ever match, cap above the limit
        set_fields({$urandom, $urandom}, 4'd15, 11'd2047);
        random_bodies(45);

        set_fields({$urandom, $urandom}, 4'd3, 11'd5);
        random_bodies(45);

        drain();
        repeat (10) @(negedge clk);

        $display("Sent %0d bodies (%0d bytes) under %0d register settings.",
                 bodies_sent, items_sent, settings_used);
        $display("Checked %0d decoded bytes and %0d completion items, %0d with the field found.",
                 bytes_seen, reports_seen, hits_seen);
        if (fail_count == 0)
            $display("tb_form_field_extract_url_decode OK");
        else
            $display("tb_form_field_extract_url_decode NOT OK");
        $finish;
    end

endmodule
